// ----- src/eds_pkg.sv -----
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types and constants of the elevator disk scheduler: request and
// result payloads, configuration register indexes and sweep policies.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam int CYL_W       = 16;
  localparam int SEEK_W      = 22;
  localparam int MAX_REQ_DEF = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SEEK_W-1:0] SEEK_MAX   = 22'h3F_FFFF;
  localparam logic [CYL_W-1:0]  MAXC_RESET = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CYL    = 2'd2;

  typedef enum logic [1:0] {
    MODE_SCAN  = 2'd0,
    MODE_CSCAN = 2'd1,
    MODE_LOOK  = 2'd2,
    MODE_CLOOK = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             is_last;
  } in_req_t;

  typedef struct packed {
    logic [CYL_W-1:0]  cylinder;
    logic [SEEK_W-1:0] total_seek;
    logic              overflowed;
    logic              end_of_run;
  } out_res_t;

endpackage

// ----- src/eds_ram.sv -----
// ----------------------------------------------------------------------------
// eds_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module eds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/elevator_disk_scheduler.sv -----
// ----------------------------------------------------------------------------
// elevator_disk_scheduler
// Collects a batch of cylinder requests into a sorted RAM by insertion, then
// emits the SCAN / C-SCAN / LOOK / C-LOOK visiting order with running seek.
// ----------------------------------------------------------------------------
// Insert: a request walks down from the top stored entry, shifting each larger
//   entry up one slot through the single RAM write port, then fills the gap.
// Emit: two passes over the stored entries, each read and checked in turn;
//   a result waits while out_stall is high.
// in_stall is high from acceptance until the store (and any emission) is done.
// Reset is synchronous; RAM contents stay undefined, no clearing pass.
module elevator_disk_scheduler #(
  parameter int MAX_REQUESTS = eds_pkg::MAX_REQ_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  eds_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output eds_pkg::out_res_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [eds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eds_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int CYL_W = eds_pkg::CYL_W;
  localparam int SEEK_W = eds_pkg::SEEK_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO = IDX_W'(2);

  typedef enum logic [3:0] {
    S_LOAD, S_INS_CMP, S_INS_PUT, S_BEGIN, S_HEAD, S_RD, S_CHK,
    S_MAX, S_JUMP, S_ZERO, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    SC_UP_GE, SC_DOWN_LT, SC_UP_LT
  } scan_t;

  state_t                state_r, state_nxt;
  scan_t                 kind_r, kind_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CYL_W-1:0]      cyl_r, cyl_nxt;
  logic                  last_r, last_nxt;
  logic                  drop_r, drop_nxt;
  logic [CYL_W-1:0]      pos_r, pos_nxt;
  logic [SEEK_W-1:0]     seek_r, seek_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [CYL_W-1:0]      pend_cyl_r, pend_cyl_nxt;
  logic [SEEK_W-1:0]     pend_seek_r, pend_seek_nxt;
  logic                  out_valid_r, out_valid_nxt;
  eds_pkg::out_res_t     out_r, out_nxt;
  eds_pkg::mode_t        mode_r;
  logic [CYL_W-1:0]      head_r;
  logic [CYL_W-1:0]      maxc_r;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [CYL_W-1:0]      ram_wdata, rd_data;

  logic                  slot_free, qual, visit, last_elem;
  logic [CYL_W-1:0]      visit_cyl, abs_diff, add_op;
  logic [SEEK_W:0]       sum_wide;
  logic [SEEK_W-1:0]     sum_sat;
  logic [CNT_W-1:0]      cnt_m1;
  state_t                end_state;
  scan_t                 end_kind;
  logic [IDX_W-1:0]      end_idx;

  eds_ram #(.WIDTH(CYL_W), .DEPTH(MAX_REQUESTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign cnt_m1    = cnt_r - CNT_ONE;

  // shared seek unit: absolute move plus saturating accumulate
  always_comb begin
    case (state_r)
      S_HEAD:  visit_cyl = head_r;
      S_MAX:   visit_cyl = maxc_r;
      S_ZERO:  visit_cyl = '0;
      default: visit_cyl = rd_data;
    endcase
    abs_diff = (visit_cyl >= pos_r) ? (visit_cyl - pos_r) : (pos_r - visit_cyl);
    add_op   = (state_r == S_JUMP) ? maxc_r : abs_diff;
    sum_wide = {1'b0, seek_r} + (SEEK_W + 1)'(add_op);
    sum_sat  = (sum_wide > (SEEK_W + 1)'(eds_pkg::SEEK_MAX)) ? eds_pkg::SEEK_MAX
                                                           : sum_wide[SEEK_W-1:0];
  end

  assign qual = (kind_r == SC_UP_GE) ? (rd_data >= head_r) : (rd_data < head_r);

  always_comb begin
    if (kind_r == SC_DOWN_LT) begin
      last_elem = (idx_r == '0);
    end else begin
      last_elem = (CNT_W'(idx_r) == cnt_m1);
    end
  end

  // where to go once the current pass over the store is done
  always_comb begin
    end_state = S_FLUSH;
    end_kind  = kind_r;
    end_idx   = idx_r;
    if (kind_r == SC_UP_GE) begin
      case (mode_r)
        eds_pkg::MODE_SCAN, eds_pkg::MODE_CSCAN: begin
          end_state = S_MAX;
        end
        eds_pkg::MODE_LOOK: begin
          end_state = S_RD;
          end_kind  = SC_DOWN_LT;
          end_idx   = cnt_m1[IDX_W-1:0];
        end
        default: begin
          end_state = S_RD;
          end_kind  = SC_UP_LT;
          end_idx   = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    cyl_nxt        = cyl_r;
    last_nxt       = last_r;
    drop_nxt       = drop_r;
    pos_nxt        = pos_r;
    seek_nxt       = seek_r;
    pend_valid_nxt = pend_valid_r;
    pend_cyl_nxt   = pend_cyl_r;
    pend_seek_nxt  = pend_seek_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = cyl_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;
    visit          = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cyl_nxt  = in_data.request_cylinder;
          last_nxt = in_data.is_last;
          if (cnt_r >= MAX_CNT) begin
            // store full: drop the request
            drop_nxt = 1'b1;
            if (in_data.is_last) begin
              state_nxt = S_BEGIN;
            end
          end else if (cnt_r == '0) begin
            idx_nxt   = '0;
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt   = cnt_r[IDX_W-1:0];
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[IDX_W-1:0];
            state_nxt = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        if (rd_data > cyl_r) begin
          // shift the larger entry up one slot and keep walking down
          ram_wdata = rd_data;
          idx_nxt   = idx_r - IDX_ONE;
          if (idx_r == IDX_ONE) begin
            state_nxt = S_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r - IDX_TWO;
          end
        end else begin
          ram_wdata = cyl_r;
          cnt_nxt   = cnt_r + CNT_ONE;
          state_nxt = last_r ? S_BEGIN : S_LOAD;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = cyl_r;
        cnt_nxt   = cnt_r + CNT_ONE;
        state_nxt = last_r ? S_BEGIN : S_LOAD;
      end
      S_BEGIN: begin
        pos_nxt   = head_r;
        seek_nxt  = '0;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (slot_free) begin
          visit     = 1'b1;
          kind_nxt  = SC_UP_GE;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (cnt_r == '0) begin
          state_nxt = end_state;
          kind_nxt  = end_kind;
          idx_nxt   = end_idx;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!qual || slot_free) begin
          visit = qual;
          if (last_elem) begin
            state_nxt = end_state;
            kind_nxt  = end_kind;
            idx_nxt   = end_idx;
          end else begin
            idx_nxt   = (kind_r == SC_DOWN_LT) ? (idx_r - IDX_ONE) : (idx_r + IDX_ONE);
            state_nxt = S_RD;
          end
        end
      end
      S_MAX: begin
        if (slot_free) begin
          visit = 1'b1;
          if (mode_r == eds_pkg::MODE_CSCAN) begin
            state_nxt = S_JUMP;
          end else begin
            kind_nxt  = SC_DOWN_LT;
            idx_nxt   = cnt_m1[IDX_W-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_JUMP: begin
        // wrap-around jump back to cylinder 0 counts the full span
        seek_nxt  = sum_sat;
        pos_nxt   = '0;
        state_nxt = S_ZERO;
      end
      S_ZERO: begin
        if (slot_free) begin
          visit     = 1'b1;
          kind_nxt  = SC_UP_LT;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.cylinder    = pend_cyl_r;
          out_nxt.total_seek  = pend_seek_r;
          out_nxt.overflowed  = drop_r;
          out_nxt.end_of_run  = 1'b1;
          cnt_nxt             = '0;
          drop_nxt            = 1'b0;
          pend_valid_nxt      = 1'b0;
          pos_nxt             = '0;
          seek_nxt            = '0;
          state_nxt           = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // hold each visit back one step so the final one can carry end_of_run
    if (visit) begin
      pos_nxt        = visit_cyl;
      seek_nxt       = sum_sat;
      pend_valid_nxt = 1'b1;
      pend_cyl_nxt   = visit_cyl;
      pend_seek_nxt  = sum_sat;
      if (pend_valid_r) begin
        out_valid_nxt      = 1'b1;
        out_nxt.cylinder   = pend_cyl_r;
        out_nxt.total_seek = pend_seek_r;
        out_nxt.overflowed = drop_r;
        out_nxt.end_of_run = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      kind_r       <= SC_UP_GE;
      idx_r        <= '0;
      cnt_r        <= '0;
      last_r       <= 1'b0;
      drop_r       <= 1'b0;
      pos_r        <= '0;
      seek_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= eds_pkg::MODE_SCAN;
      head_r       <= '0;
      maxc_r       <= eds_pkg::MAXC_RESET;
    end else begin
      state_r      <= state_nxt;
      kind_r       <= kind_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      last_r       <= last_nxt;
      drop_r       <= drop_nxt;
      pos_r        <= pos_nxt;
      seek_r       <= seek_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          eds_pkg::CFG_MODE:       mode_r <= eds_pkg::mode_t'(cfg_data[1:0]);
          eds_pkg::CFG_START_HEAD: head_r <= cfg_data[CYL_W-1:0];
          eds_pkg::CFG_MAX_CYL:    maxc_r <= cfg_data[CYL_W-1:0];
          default: begin
          end
        endcase
      end
    end
    cyl_r       <= cyl_nxt;
    pend_cyl_r  <= pend_cyl_nxt;
    pend_seek_r <= pend_seek_nxt;
    out_r       <= out_nxt;
  end

endmodule

// ----- src/eds_checker.sv -----
// ----------------------------------------------------------------------------
// eds_checker
// Port-level checks of the elevator disk scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module eds_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input eds_pkg::out_res_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // mid-run results are only produced while the block is busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.end_of_run |-> in_stall)
    else $error("request taken while a run is being emitted");

  // a new request is only taken once all but the final visit are out
  a_take_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid || out_data.end_of_run)
    else $error("request taken with a mid-run result pending");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind elevator_disk_scheduler eds_checker u_eds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
